[hw/rtl/truncated_taylor_exp_unit_defines.svh]
// Assertion macros shared by the truncated Taylor exp unit RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef TRUNCATED_TAYLOR_EXP_UNIT_DEFINES_SVH
`define TRUNCATED_TAYLOR_EXP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TTE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define TTE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/tte_pkg.sv]
// Shared types and constants for the truncated Taylor exp unit.
// No dependencies; imported by every module of the unit.
package tte_pkg;

  localparam int X_W        = 26;          // input point width
  localparam int M_W        = 63;          // term magnitude / quotient width
  localparam int S_W        = 64;          // running sum and result width
  localparam int MUL_W      = 32;          // slice of the term fed to the multiplier
  localparam int PP_W       = MUL_W + X_W; // partial product width
  localparam int PROD_W     = M_W + X_W;   // full term-times-x product width
  localparam int TC_W       = 8;           // term_count register width
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_MODE = 1'b1;

  localparam logic [TC_W-1:0] TERM_COUNT_RST = 8'd10;

  localparam logic [S_W-1:0] S_MAX = {1'b0, {(S_W-1){1'b1}}};
  localparam logic [S_W-1:0] S_MIN = {1'b1, {(S_W-1){1'b0}}};

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_CHECK     = 11'b000_0000_0010,
    ST_MUL_LO    = 11'b000_0000_0100,
    ST_MUL_HI    = 11'b000_0000_1000,
    ST_MUL_ADD   = 11'b000_0001_0000,
    ST_LOAD_TERM = 11'b000_0010_0000,
    ST_DIV_TERM  = 11'b000_0100_0000,
    ST_ACCUM     = 11'b000_1000_0000,
    ST_RECIP_CHK = 11'b001_0000_0000,
    ST_DIV_RECIP = 11'b010_0000_0000,
    ST_FINISH    = 11'b100_0000_0000
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic init;        // capture x, reset sum and term
    logic mul_lo;      // low slice of term times |x|
    logic mul_hi;      // high slice of term times |x|
    logic mul_add;     // merge the two partial products
    logic load_term;   // start product / k division
    logic accum;       // take new term, update sum
    logic recip_bad;   // reciprocal of non-positive sum
    logic load_recip;  // start 2^(2F) / sum division
    logic recip_take;  // take reciprocal quotient
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic more_terms;
    logic div_done;
    logic recip_en;
    logic sum_pos;
  } stat_t;

endpackage

[hw/rtl/tte_div.sv]
// Restoring serial divider, one quotient bit per cycle, for the exp unit.
// Depends on tte_pkg for the divisor and quotient widths.
module tte_div #(
  parameter int XW = 69
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic [XW-1:0]           dividend,
  input  logic [tte_pkg::M_W-1:0] divisor,
  output logic [tte_pkg::M_W-1:0] quotient,
  output logic                    q_ovf,
  output logic                    done
);
  import tte_pkg::*;

  localparam int CW = $clog2(XW + 1);

  logic [XW-1:0]  dvd;
  logic [M_W-1:0] dsr;
  logic [M_W-1:0] rem;
  logic [M_W-1:0] quo;
  logic           ovf;
  logic [CW-1:0]  cnt;
  logic           run;

  logic [M_W:0]   rem_sh;
  logic [M_W:0]   rem_sub;
  logic           ge;

  // Remainder stays below the divisor, so one extra bit holds the shifted value.
  assign rem_sh  = {rem, dvd[XW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign ge      = (rem_sh >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        run <= 1'b1;
        cnt <= CW'(XW);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (run) begin
      dvd <= dvd << 1;
      rem <= ge ? rem_sub[M_W-1:0] : rem_sh[M_W-1:0];
      quo <= {quo[M_W-2:0], ge};
      // a set top bit being shifted out means the quotient passed 2^63 - 1
      ovf <= ovf | quo[M_W-1];
    end
  end

  assign quotient = quo;
  assign q_ovf    = ovf;

endmodule

[hw/rtl/tte_dp.sv]
// Datapath of the truncated Taylor exp unit: term, sum, multiplier slices,
// shared serial divider. Depends on tte_pkg and tte_div.
module tte_dp #(
  parameter int FRAC_BITS  = 20,
  parameter int MAX_DEGREE = 255
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tte_pkg::cmd_t                  cmd,
  input  logic signed [tte_pkg::X_W-1:0] x_value,
  input  logic [tte_pkg::TC_W-1:0]       term_count,
  input  logic                           reciprocal_mode,
  output tte_pkg::stat_t                 stat,
  output logic signed [tte_pkg::S_W-1:0] approx_value,
  output logic                           out_of_range
);
  import tte_pkg::*;

  localparam int DW = PROD_W - FRAC_BITS;
  localparam int RW = 2 * FRAC_BITS + 1;
  localparam int XW = (DW > RW) ? DW : RW;
  localparam int KW = $clog2(MAX_DEGREE + 2);

  logic                  neg;
  logic [X_W-1:0]        ax;
  logic [M_W-1:0]        m;
  logic signed [S_W-1:0] s;
  logic                  flag;
  logic                  stopped;
  logic [KW-1:0]         k;
  logic [KW-1:0]         deg;
  logic [PP_W-1:0]       pp;
  logic [PROD_W-1:0]     acc;

  logic [X_W-1:0]        x_raw;
  logic [X_W-1:0]        ax_init;
  logic [31:0]           tc_ext;
  logic [KW-1:0]         deg_init;
  logic [MUL_W-1:0]      mul_a;
  logic [PP_W-1:0]       prod;
  logic                  tneg;
  logic [S_W-1:0]        sat;
  logic [S_W:0]          s_ext;
  logic [S_W:0]          q_ext;
  logic [S_W:0]          sum;
  logic                  sum_ovf;
  logic [XW-1:0]         recip_num;
  logic [XW-1:0]         div_dividend;
  logic [M_W-1:0]        div_divisor;
  logic [M_W-1:0]        quo;
  logic                  q_ovf;
  logic                  div_done;

  assign x_raw    = x_value;
  assign ax_init  = x_raw[X_W-1] ? (~x_raw + X_W'(1)) : x_raw;
  assign tc_ext   = 32'(term_count);
  assign deg_init = (tc_ext > 32'(MAX_DEGREE)) ? KW'(MAX_DEGREE) : KW'(term_count);

  assign mul_a = cmd.mul_hi ? {1'b0, m[M_W-1:MUL_W]} : m[MUL_W-1:0];
  assign prod  = mul_a * ax;

  assign tneg    = neg & k[0];
  assign sat     = tneg ? S_MIN : S_MAX;
  assign s_ext   = {s[S_W-1], s};
  assign q_ext   = {2'b00, quo};
  assign sum     = tneg ? (s_ext - q_ext) : (s_ext + q_ext);
  assign sum_ovf = sum[S_W] ^ sum[S_W-1];

  assign recip_num    = XW'(1) << (2 * FRAC_BITS);
  assign div_dividend = cmd.load_recip ? recip_num : XW'(acc >> FRAC_BITS);
  assign div_divisor  = cmd.load_recip ? s[M_W-1:0] : M_W'(k);

  tte_div #(
    .XW (XW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd.load_term | cmd.load_recip),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quo),
    .q_ovf    (q_ovf),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flag    <= 1'b0;
      stopped <= 1'b0;
    end else begin
      if (cmd.init) begin
        flag    <= 1'b0;
        stopped <= 1'b0;
      end
      if (cmd.accum && (q_ovf || sum_ovf)) begin
        flag    <= 1'b1;
        stopped <= 1'b1;
      end
      if (cmd.recip_bad || (cmd.recip_take && q_ovf)) begin
        flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      neg <= x_raw[X_W-1];
      ax  <= ax_init;
      m   <= M_W'(1) << FRAC_BITS;
      s   <= S_W'(1) << FRAC_BITS;
      k   <= KW'(1);
      deg <= deg_init;
    end
    if (cmd.mul_lo) begin
      pp <= prod;
    end
    if (cmd.mul_hi) begin
      acc <= PROD_W'(pp);
      pp  <= prod;
    end
    if (cmd.mul_add) begin
      acc <= acc + (PROD_W'(pp) << MUL_W);
    end
    if (cmd.accum) begin
      k <= k + KW'(1);
      if (q_ovf) begin
        s <= sat;
      end else begin
        m <= quo;
        s <= sum_ovf ? sat : sum[S_W-1:0];
      end
    end
    if (cmd.recip_bad) begin
      s <= S_MAX;
    end
    if (cmd.recip_take) begin
      s <= q_ovf ? S_MAX : {1'b0, quo};
    end
  end

  assign stat.more_terms = (k <= deg) && (m != '0) && !stopped;
  assign stat.div_done   = div_done;
  assign stat.recip_en   = reciprocal_mode;
  assign stat.sum_pos    = !s[S_W-1] && (s != '0);

  assign approx_value = s;
  assign out_of_range = flag;

endmodule

[hw/rtl/tte_ctrl.sv]
// Sequencing state machine of the truncated Taylor exp unit.
// Depends on tte_pkg and the assertion macro header.
`include "truncated_taylor_exp_unit_defines.svh"

module tte_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  tte_pkg::stat_t stat,
  output tte_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);
  import tte_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.init   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = stat.more_terms ? ST_MUL_LO : ST_RECIP_CHK;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_MUL_ADD;
      end
      ST_MUL_ADD: begin
        cmd.mul_add = 1'b1;
        state_next  = ST_LOAD_TERM;
      end
      ST_LOAD_TERM: begin
        cmd.load_term = 1'b1;
        state_next    = ST_DIV_TERM;
      end
      ST_DIV_TERM: begin
        if (stat.div_done) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = ST_CHECK;
      end
      ST_RECIP_CHK: begin
        if (!stat.recip_en) begin
          state_next = ST_FINISH;
        end else if (!stat.sum_pos) begin
          cmd.recip_bad = 1'b1;
          state_next    = ST_FINISH;
        end else begin
          cmd.load_recip = 1'b1;
          state_next     = ST_DIV_RECIP;
        end
      end
      ST_DIV_RECIP: begin
        if (stat.div_done) begin
          cmd.recip_take = 1'b1;
          state_next     = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_FINISH);

  `TTE_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `TTE_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy && !done)
  `TTE_ASSERT_IMPL(a_div_done_wait, clk, rst, stat.div_done,
                   (state == ST_DIV_TERM) || (state == ST_DIV_RECIP))

endmodule

[hw/rtl/truncated_taylor_exp_unit.sv]
// Top level of the truncated Taylor exp unit: configuration registers,
// controller and datapath. Depends on tte_pkg, tte_ctrl, tte_dp.
//
//   Channel   Handshake            Payload
//   --------  -------------------  ---------------------------------------
//   input     start & !busy        x_value (s26, F fraction bits)
//   result    done (1-cycle pulse) approx_value (s64), out_of_range
//   config    cfg_write            cfg_index (0 term_count, 1 recip), cfg_data
//
// One item at a time. Each series term takes two 32-bit multiplier
// slices, a merge, then the serial divider by k at one bit a cycle on an
// XW-bit dividend, with XW = max(89 - FRAC_BITS, 2*FRAC_BITS + 1) (69 by
// default). Reciprocal mode then adds one division of 2^(2F) by the sum.
// Synchronous reset returns term_count to 10 and reciprocal_mode to 0.
// The receiver cannot stall: done marks the result for exactly one cycle.
module truncated_taylor_exp_unit #(
  parameter int FRAC_BITS  = 20,
  parameter int MAX_DEGREE = 255
) (
  input  logic                                clk,
  input  logic                                rst,
  // item input
  input  logic                                start,
  output logic                                busy,
  input  logic signed [tte_pkg::X_W-1:0]      x_value,
  // result
  output logic                                done,
  output logic signed [tte_pkg::S_W-1:0]      approx_value,
  output logic                                out_of_range,
  // configuration writes
  input  logic                                cfg_write,
  input  logic [tte_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tte_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tte_pkg::*;

  logic [TC_W-1:0] term_count;
  logic            reciprocal_mode;
  cmd_t            cmd;
  stat_t           stat;

  // Configuration registers: the user must write them only while no item is in flight; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      term_count      <= TERM_COUNT_RST;
      reciprocal_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TERM_COUNT: term_count      <= cfg_data[TC_W-1:0];
        REG_RECIP_MODE: reciprocal_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: walks the term loop, then the optional reciprocal.
  tte_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Arithmetic: holds term and sum; the result ports read its registers.
  tte_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .x_value         (x_value),
    .term_count      (term_count),
    .reciprocal_mode (reciprocal_mode),
    .stat            (stat),
    .approx_value    (approx_value),
    .out_of_range    (out_of_range)
  );

endmodule
